// ===== hw/rtl/dte_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dte_pkg
// types, codes and calendar constants shared by the date to epoch pipeline
// ----------------------------------------------------------------------------
package dte_pkg;

  localparam int unsigned SecsPerMin  = 60;
  localparam int unsigned SecsPerHour = 60 * SecsPerMin;
  localparam int unsigned SecsPerDay  = 24 * SecsPerHour;
  localparam int unsigned DaysPerYear = 365;
  localparam int unsigned CenturySplit = 70;
  localparam int unsigned YearsTo2000  = 2000 - 1970;

  localparam int unsigned LenShort = 10;
  localparam int unsigned LenLong  = 12;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_BAD_LEN   = 2'd1,
    STS_BAD_FIELD = 2'd2,
    STS_NOT_POS   = 2'd3
  } status_e;

  typedef struct packed {
    logic [15:0] year_chars;
    logic [15:0] month_chars;
    logic [15:0] day_chars;
    logic [15:0] hour_chars;
    logic [15:0] minute_chars;
    logic [15:0] second_chars;
    logic [5:0]  text_length;
  } in_t;

  typedef struct packed {
    logic [31:0] epoch_seconds;
    status_e     status;
  } out_t;

  // days before the first of a month in a common year, month 1..12
  function automatic logic [8:0] days_before_month(input logic [3:0] mo);
    logic [8:0] d;
    unique case (mo)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== hw/rtl/dte_pair_dec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dte_pair_dec
// decodes two ascii digits, first in the upper byte, into a value 0..99
// ----------------------------------------------------------------------------
module dte_pair_dec (
  input  logic [15:0] chars_i,
  output logic [6:0]  val_o,
  output logic        ok_o
);

  logic [7:0] hi, lo;
  logic       hi_ok, lo_ok;

  assign hi = chars_i[15:8];
  assign lo = chars_i[7:0];

  assign hi_ok = (hi >= 8'h30) && (hi <= 8'h39);
  assign lo_ok = (lo >= 8'h30) && (lo <= 8'h39);
  assign ok_o  = hi_ok && lo_ok;

  // only the low nibble matters once the digit checks pass
  assign val_o = 7'(hi[3:0]) * 7'd10 + 7'(lo[3:0]);

endmodule

// ===== hw/rtl/date_text_to_epoch_seconds.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_text_to_epoch_seconds
// ascii yymmddhhmm[ss] date text to seconds since 1970-01-01, modulo 2^32
// ----------------------------------------------------------------------------
// Four-stage pipeline that takes one item per clock while the output is not
// stalled and returns one result per item. Stage 1 checks the length and
// decodes the digit pairs, stage 2 forms the day count (years in closed form,
// month table, leap day, day of month) and the minute of day, stage 3 does
// the 32 x 17 multiply by seconds per day, stage 4 adds the pieces and sets
// the status. All stages move together on one enable: when the output holds
// an item that is not taken, the whole pipe holds, so nothing is lost or
// repeated. Years 00..69 mean 20yy, 70..99 mean 19yy. Status 1 is a bad
// length, 2 a non-digit or a month outside 1..12 (both with zero seconds),
// 3 a result that is zero or has bit 31 set (value still given).
// ----------------------------------------------------------------------------
module date_text_to_epoch_seconds (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dte_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output dte_pkg::out_t out_data_o
);

  import dte_pkg::*;

  // global advance enable, open whenever the last stage is empty or drained
  logic en;

  // ---------------- stage 1: length check and digit decode ----------------
  logic [6:0] yy_v, mo_v, dd_v, hh_v, mi_v, ss_v;
  logic       yy_ok, mo_ok, dd_ok, hh_ok, mi_ok, ss_ok;
  logic       len_short, len_long, fields_ok;
  status_e    st1_d;
  logic [6:0] idx1_d;

  dte_pair_dec u_yy (.chars_i(in_data_i.year_chars),   .val_o(yy_v), .ok_o(yy_ok));
  dte_pair_dec u_mo (.chars_i(in_data_i.month_chars),  .val_o(mo_v), .ok_o(mo_ok));
  dte_pair_dec u_dd (.chars_i(in_data_i.day_chars),    .val_o(dd_v), .ok_o(dd_ok));
  dte_pair_dec u_hh (.chars_i(in_data_i.hour_chars),   .val_o(hh_v), .ok_o(hh_ok));
  dte_pair_dec u_mi (.chars_i(in_data_i.minute_chars), .val_o(mi_v), .ok_o(mi_ok));
  dte_pair_dec u_ss (.chars_i(in_data_i.second_chars), .val_o(ss_v), .ok_o(ss_ok));

  assign len_short = (in_data_i.text_length == 6'(LenShort));
  assign len_long  = (in_data_i.text_length == 6'(LenLong));

  // seconds pair only counts in the long form
  assign fields_ok = yy_ok && mo_ok && dd_ok && hh_ok && mi_ok && (ss_ok || !len_long)
                     && (mo_v >= 7'd1) && (mo_v <= 7'd12);

  always_comb begin
    if (!len_short && !len_long) begin
      st1_d = STS_BAD_LEN;
    end else if (!fields_ok) begin
      st1_d = STS_BAD_FIELD;
    end else begin
      st1_d = STS_OK;
    end
  end

  // years since 1970, 0..99
  assign idx1_d = (yy_v < 7'(CenturySplit)) ? yy_v + 7'(YearsTo2000)
                                            : yy_v - 7'(CenturySplit);

  logic       v1_q;
  status_e    st1_q;
  logic [6:0] idx1_q, dd1_q, hh1_q, mi1_q, ss1_q;
  logic [3:0] mo1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st1_q  <= st1_d;
      idx1_q <= idx1_d;
      mo1_q  <= mo_v[3:0];
      dd1_q  <= dd_v;
      hh1_q  <= hh_v;
      mi1_q  <= mi_v;
      ss1_q  <= len_long ? ss_v : 7'd0;
    end
  end

  // ---------------- stage 2: day count and minute of day ----------------
  // within 1970..2069 the century terms cancel (2000 is a leap year), so
  // leap days before the year are (idx + 1) / 4
  logic [16:0] year_days;
  logic [6:0]  idx_p1;
  logic [4:0]  leap_days;
  logic        leap_year, leap_add;
  logic [31:0] days2_d;
  logic [12:0] mins2_d;

  assign year_days = 17'(idx1_q) * 17'(DaysPerYear);
  assign idx_p1    = idx1_q + 7'd1;
  assign leap_days = idx_p1[6:2];
  assign leap_year = (idx1_q[1:0] == 2'd2);
  assign leap_add  = leap_year && (mo1_q > 4'd2);

  // day 00 wraps to minus one day here
  assign days2_d = 32'(year_days) + 32'(leap_days) + 32'(days_before_month(mo1_q))
                 + 32'(leap_add) + 32'(dd1_q) - 32'd1;
  assign mins2_d = 13'(hh1_q) * 13'(SecsPerMin) + 13'(mi1_q);

  logic        v2_q;
  status_e     st2_q;
  logic [31:0] days2_q;
  logic [12:0] mins2_q;
  logic [6:0]  ss2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st2_q   <= st1_q;
      days2_q <= days2_d;
      mins2_q <= mins2_d;
      ss2_q   <= ss1_q;
    end
  end

  // ---------------- stage 3: scale to seconds ----------------
  logic        v3_q;
  status_e     st3_q;
  logic [31:0] dsec3_q;
  logic [18:0] rsec3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st3_q   <= st2_q;
      dsec3_q <= days2_q * 32'(SecsPerDay);
      rsec3_q <= 19'(mins2_q) * 19'(SecsPerMin) + 19'(ss2_q);
    end
  end

  // ---------------- stage 4: final sum and status ----------------
  logic [31:0] secs4;
  out_t        out4_d;

  assign secs4 = dsec3_q + 32'(rsec3_q);

  always_comb begin
    if (st3_q != STS_OK) begin
      out4_d.epoch_seconds = 32'd0;
      out4_d.status        = st3_q;
    end else begin
      out4_d.epoch_seconds = secs4;
      out4_d.status        = ((secs4 == 32'd0) || secs4[31]) ? STS_NOT_POS : STS_OK;
    end
  end

  logic v4_q;
  out_t out4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out4_q <= out4_d;
    end
  end

  assign en          = !v4_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v4_q;
  assign out_data_o  = out4_q;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the date text to epoch seconds pipeline
// ----------------------------------------------------------------------------
// Drives ascii date items through the valid/ready input and predicts each
// result with a separate calendar calculation: Gregorian leap years in
// closed form, a month offset table and 32-bit wrapping sums. Results are
// checked in order against a queue of predicted epochs. The stimulus is a
// directed set of calendar edges, length codes and bad fields. After that
// come random dates, mostly well formed, plus corrupted and pure noise
// items. Both sides idle at random, with one stretch at full rate, a long
// receiver hold-off and two sender pauses until the pipe drains.
// ----------------------------------------------------------------------------
module tb;
  import dte_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned DrainCycles = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  // predicted results in order of acceptance
  out_t pending_epochs [$];

  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned status_seen [4] = '{0, 0, 0, 0};
  int unsigned cycle_count = 0;

  // receiver controls: forced hold-off length and no-idle stretch
  int unsigned hold_left = 0;
  bit no_idle = 1'b0;

  // days before the first of each month in a common year
  int unsigned month_start [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  date_text_to_epoch_seconds dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // one ascii digit pair, true when both characters are digits
  function automatic bit digit_pair(input logic [15:0] c, output int unsigned v);
    int unsigned hi;
    int unsigned lo;
    hi = c[15:8];
    lo = c[7:0];
    v = 10 * (hi - 32'h30) + (lo - 32'h30);
    return hi >= 32'h30 && hi <= 32'h39 && lo >= 32'h30 && lo <= 32'h39;
  endfunction

  // leap years in 1..n, Gregorian rules
  function automatic int unsigned leaps_upto(input int unsigned n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  function automatic out_t predict_epoch(input in_t it);
    out_t r;
    int unsigned yy, mo, dd, hh, mi, ss;
    int unsigned year, days, secs;
    bit ok;
    bit leap;
    yy = 0; mo = 0; dd = 0; hh = 0; mi = 0; ss = 0;
    r = '0;
    if (it.text_length != LenShort && it.text_length != LenLong) begin
      r.status = STS_BAD_LEN;
      return r;
    end
    ok = digit_pair(it.year_chars, yy);
    ok = digit_pair(it.month_chars, mo) && ok;
    ok = digit_pair(it.day_chars, dd) && ok;
    ok = digit_pair(it.hour_chars, hh) && ok;
    ok = digit_pair(it.minute_chars, mi) && ok;
    // seconds only count in the long form
    if (it.text_length == LenLong) ok = digit_pair(it.second_chars, ss) && ok;
    else ss = 0;
    if (!ok || mo < 1 || mo > 12) begin
      r.status = STS_BAD_FIELD;
      return r;
    end
    year = (yy < 70) ? 2000 + yy : 1900 + yy;
    leap = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
    days = 365 * (year - 1970) + leaps_upto(year - 1) - leaps_upto(1969);
    days = days + month_start[4'(mo - 1)];
    if (mo > 2 && leap) days = days + 1;
    // day 00 wraps to minus one day
    secs = days * 86400 + (dd - 1) * 86400 + hh * 3600 + mi * 60 + ss;
    r.epoch_seconds = secs;
    r.status = (secs == 0 || secs[31]) ? STS_NOT_POS : STS_OK;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // item builders
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] ascii_pair(input int unsigned v);
    ascii_pair = {8'h30 + 8'(v / 10), 8'h30 + 8'(v % 10)};
  endfunction

  function automatic in_t make_date(input int unsigned yy, input int unsigned mo,
                                    input int unsigned dd, input int unsigned hh,
                                    input int unsigned mi, input int unsigned ss,
                                    input int unsigned len);
    in_t it;
    it.year_chars = ascii_pair(yy);
    it.month_chars = ascii_pair(mo);
    it.day_chars = ascii_pair(dd);
    it.hour_chars = ascii_pair(hh);
    it.minute_chars = ascii_pair(mi);
    it.second_chars = ascii_pair(ss);
    it.text_length = 6'(len);
    return it;
  endfunction

  // mostly well formed dates with random content, some broken, some noise
  function automatic in_t random_date();
    in_t it;
    int unsigned pick;
    int unsigned dd;
    logic [7:0] junk;
    pick = $urandom_range(99);
    dd = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(31, 1);
    it = make_date($urandom_range(99), $urandom_range(12, 1), dd,
                   ($urandom_range(7) == 0) ? $urandom_range(99) : $urandom_range(23),
                   ($urandom_range(7) == 0) ? $urandom_range(99) : $urandom_range(59),
                   ($urandom_range(7) == 0) ? $urandom_range(99) : $urandom_range(59),
                   $urandom_range(1) ? LenLong : LenShort);
    // short form carries junk in the unused seconds pair
    if (it.text_length == LenShort && $urandom_range(1)) it.second_chars = 16'($urandom);
    if (pick < 72) begin
      return it;
    end else if (pick < 82) begin
      // one character replaced by a random byte
      junk = 8'($urandom);
      case ($urandom_range(11))
        0: it.year_chars[15:8] = junk;
        1: it.year_chars[7:0] = junk;
        2: it.month_chars[15:8] = junk;
        3: it.month_chars[7:0] = junk;
        4: it.day_chars[15:8] = junk;
        5: it.day_chars[7:0] = junk;
        6: it.hour_chars[15:8] = junk;
        7: it.hour_chars[7:0] = junk;
        8: it.minute_chars[15:8] = junk;
        9: it.minute_chars[7:0] = junk;
        10: it.second_chars[15:8] = junk;
        default: it.second_chars[7:0] = junk;
      endcase
    end else if (pick < 90) begin
      // month zero or past twelve
      it.month_chars = ($urandom_range(3) == 0) ? ascii_pair(0)
                                                 : ascii_pair($urandom_range(99, 13));
    end else begin
      it.year_chars = 16'($urandom);
      it.month_chars = 16'($urandom);
      it.day_chars = 16'($urandom);
      it.hour_chars = 16'($urandom);
      it.minute_chars = 16'($urandom);
      it.second_chars = 16'($urandom);
      it.text_length = ($urandom_range(1)) ? 6'($urandom) : 6'(LenShort + 2 * $urandom_range(1));
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offer one item, wait for acceptance, then queue its prediction.
  // valid stays high after acceptance so back-to-back items need no toggle
  task automatic offer_date(input in_t it);
    int unsigned gap;
    gap = 0;
    while (!no_idle && $urandom_range(99) < 35) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_epochs.push_back(predict_epoch(it));
    items_sent++;
  endtask

  task automatic wait_drained();
    while (pending_epochs.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // receiver side and checking
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= no_idle || ($urandom_range(99) >= 35);
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    errors++;
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      status_seen[out_data_o.status]++;
      if (pending_epochs.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing pending", out_data_o));
      end else begin
        want = pending_epochs.pop_front();
        if (out_data_o.epoch_seconds !== want.epoch_seconds)
          report_mismatch($sformatf("epoch_seconds %h, predicted %h",
                                    out_data_o.epoch_seconds, want.epoch_seconds));
        if (out_data_o.status !== want.status)
          report_mismatch($sformatf("status %0d, predicted %0d",
                                    out_data_o.status, want.status));
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // epoch start, the bit 31 boundary, century split, leap days, day 00
  task automatic test_calendar_edges();
    offer_date(make_date(70, 1, 1, 0, 0, 0, LenLong));
    offer_date(make_date(70, 1, 1, 0, 0, 1, LenLong));
    offer_date(make_date(38, 1, 19, 3, 14, 7, LenLong));
    offer_date(make_date(38, 1, 19, 3, 14, 8, LenLong));
    offer_date(make_date(0, 2, 29, 12, 0, 0, LenShort));
    offer_date(make_date(0, 3, 1, 0, 0, 0, LenLong));
    offer_date(make_date(69, 12, 31, 23, 59, 59, LenLong));
    offer_date(make_date(99, 12, 31, 23, 59, 59, LenLong));
    offer_date(make_date(72, 3, 1, 0, 0, 0, LenShort));
    offer_date(make_date(70, 1, 0, 0, 0, 0, LenLong));
    offer_date(make_date(99, 12, 99, 99, 99, 99, LenLong));
  endtask

  // lengths other than ten and twelve, and seconds ignored at ten
  task automatic test_length_codes();
    in_t it;
    it = '0;
    offer_date(it);
    it = '1;
    offer_date(it);
    it = make_date(85, 6, 15, 10, 30, 0, 9);
    offer_date(it);
    it.text_length = 6'd11;
    offer_date(it);
    it.text_length = 6'd13;
    offer_date(it);
    it = make_date(85, 6, 15, 10, 30, 0, LenShort);
    it.second_chars = 16'hffff;
    offer_date(it);
  endtask

  // non-digit characters next to the digit range, month out of range
  task automatic test_bad_fields();
    in_t it;
    offer_date(make_date(90, 0, 1, 0, 0, 0, LenShort));
    offer_date(make_date(90, 13, 1, 0, 0, 0, LenLong));
    it = make_date(90, 5, 1, 0, 0, 0, LenShort);
    it.year_chars[15:8] = 8'h2f;
    offer_date(it);
    it = make_date(90, 5, 1, 0, 0, 0, LenShort);
    it.minute_chars[7:0] = 8'h3a;
    offer_date(it);
    it = make_date(90, 5, 1, 0, 0, 0, LenLong);
    it.second_chars = 16'h3a30;
    offer_date(it);
    it = '1;
    it.text_length = 6'(LenLong);
    offer_date(it);
    it = make_date(90, 5, 1, 0, 0, 0, LenLong);
    it.day_chars = 16'h0000;
    offer_date(it);
  endtask

  task automatic test_random_dates(input int unsigned n);
    repeat (n) offer_date(random_date());
  endtask

  // no idling on either side
  task automatic test_full_rate(input int unsigned n);
    no_idle = 1'b1;
    repeat (n) offer_date(random_date());
    no_idle = 1'b0;
  endtask

  // receiver holds off long enough that the pipe fills and stalls the input
  task automatic test_backpressure();
    hold_left = 150;
    repeat (24) offer_date(random_date());
  endtask

  // sender pauses until every predicted result is back, twice
  task automatic test_drain_pause();
    repeat (2) begin
      repeat (15) offer_date(random_date());
      in_valid_i <= 1'b0;
      wait_drained();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_calendar_edges();
    test_length_codes();
    test_bad_fields();
    test_random_dates(200);
    test_full_rate(80);
    test_backpressure();
    test_drain_pause();
    test_random_dates(200);

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_epochs.size() != 0) report_mismatch("predictions left over at the end");

    $display("covered %0d items, %0d results: ok %0d, bad length %0d, bad field %0d, %s %0d",
             items_sent, results_seen, status_seen[STS_OK], status_seen[STS_BAD_LEN],
             status_seen[STS_BAD_FIELD], "not positive", status_seen[STS_NOT_POS]);
    $display("included random idling, a full-rate stretch, a long output stall and drains");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
